### sv/dpie_pkg.sv
// Package for the data-processing immediate execute unit.
// Holds the instruction class and opcode codes and the structs shared by the modules.
// No dependencies.
package dpie_pkg;

    localparam int unsigned XLEN      = 64;
    localparam int unsigned REG_DEPTH = 31;
    localparam int unsigned REG_AW    = 5;

    localparam logic [REG_AW-1:0] ZERO_REG = 5'd31;

    // Instruction classes, bits 25:23.
    localparam logic [2:0] CLS_ARITH = 3'h2;
    localparam logic [2:0] CLS_WIDE  = 3'h5;

    // Wide move opcodes, bits 30:29.
    localparam logic [1:0] WIDE_MOVN = 2'h0;
    localparam logic [1:0] WIDE_BAD  = 2'h1;
    localparam logic [1:0] WIDE_MOVZ = 2'h2;
    localparam logic [1:0] WIDE_MOVK = 2'h3;

    localparam logic [15:0] HALF_MASK = 16'hFFFF;

    // Register file write request.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_wr_req;

    // Result of one executed instruction.
    typedef struct packed {
        logic              recognized;
        logic              write_done;
        logic [REG_AW-1:0] dest_index;
        logic [XLEN-1:0]   dest_value;
        logic [3:0]        nzcv;
    } t_exec_res;

endpackage

### sv/dpie_regfile.sv
// General register file: a 31-entry synchronous memory with a registered read.
// Valid bits give the zero reset; a bypass register forwards the latest write.
// Depends on dpie_pkg.
module dpie_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [dpie_pkg::REG_AW-1:0]   i_rd_addr,
    input  dpie_pkg::t_wr_req             i_wr,
    output logic [dpie_pkg::XLEN-1:0]     o_rd_data
);

    logic [dpie_pkg::XLEN-1:0]      r_mem [dpie_pkg::REG_DEPTH];
    logic [dpie_pkg::REG_DEPTH-1:0] r_valid;
    logic [dpie_pkg::XLEN-1:0]      r_rd_data;
    logic [dpie_pkg::REG_AW-1:0]    r_rd_addr;
    logic                           r_rd_ok;
    dpie_pkg::t_wr_req              r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.addr != dpie_pkg::ZERO_REG) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en && i_rd_addr != dpie_pkg::ZERO_REG) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_ok   <= 1'b0;
            r_rd_addr <= dpie_pkg::ZERO_REG;
            r_byp     <= '0;
        end else begin
            if (i_wr.en && i_wr.addr != dpie_pkg::ZERO_REG) begin
                r_valid[i_wr.addr] <= 1'b1;
                r_byp              <= i_wr;
            end
            if (i_rd_en) begin
                r_rd_addr <= i_rd_addr;
                r_rd_ok   <= (i_rd_addr != dpie_pkg::ZERO_REG) ? r_valid[i_rd_addr] : 1'b0;
            end
        end
    end

    // The bypass always holds the most recent write, so a hit is never stale.
    always_comb begin
        if (r_byp.en && r_byp.addr == r_rd_addr) begin
            o_rd_data = r_byp.data;
        end else if (r_rd_ok) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

`ifndef SYNTH
    a_byp_never_zero_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp.en |-> r_byp.addr != dpie_pkg::ZERO_REG)
        else $error("bypass holds a write to the zero register");
    a_wr_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && i_wr.addr != dpie_pkg::ZERO_REG) |=> r_valid[$past(i_wr.addr)])
        else $error("write did not mark its entry valid");
    a_zero_reg_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_addr == dpie_pkg::ZERO_REG) |-> o_rd_data == '0)
        else $error("zero register read returned nonzero data");
`endif

endmodule

### sv/dpie_exec.sv
// Execute logic: add/subtract immediate with flags, and the wide moves.
// Purely combinational; the source operand comes from the register file read.
// Depends on dpie_pkg.
module dpie_exec (
    input  logic [31:0]               i_instr,
    input  logic [dpie_pkg::XLEN-1:0] i_src,
    input  logic [3:0]                i_nzcv,
    output dpie_pkg::t_exec_res       o_res
);

    logic [2:0]  cls;
    logic        sf;
    logic [1:0]  opc;
    logic [4:0]  rd;
    logic [63:0] src_cut;
    logic [63:0] imm;
    logic [63:0] b_op;
    logic [64:0] sum;
    logic [63:0] ar_res;
    logic        carry;
    logic        n_flag;
    logic        v_flag;
    logic [63:0] ovf_vec;
    logic [5:0]  sh;
    logic [63:0] part;
    logic [63:0] hmask;
    logic [63:0] wide_val;

    assign cls = i_instr[25:23];
    assign sf  = i_instr[31];
    assign opc = i_instr[30:29];
    assign rd  = i_instr[4:0];

    assign src_cut = sf ? i_src : {32'd0, i_src[31:0]};

    always_comb begin
        imm = i_instr[22] ? {40'd0, i_instr[21:10], 12'd0} : {52'd0, i_instr[21:10]};
        if (opc[1]) begin
            b_op = sf ? ~imm : {32'd0, ~imm[31:0]};
        end else begin
            b_op = imm;
        end
        sum = {1'b0, src_cut} + {1'b0, b_op} + {64'd0, opc[1]};
        if (sf) begin
            ar_res = sum[63:0];
            carry  = sum[64];
        end else begin
            ar_res = {32'd0, sum[31:0]};
            carry  = sum[32];
        end
        ovf_vec = ~(src_cut ^ b_op) & (src_cut ^ ar_res);
        n_flag  = sf ? ar_res[63] : ar_res[31];
        v_flag  = sf ? ovf_vec[63] : ovf_vec[31];
    end

    // In the 32-bit form a halfword at 32 or 48 falls away in the final cut.
    always_comb begin
        sh    = {i_instr[22:21], 4'd0};
        part  = {48'd0, i_instr[20:5]} << sh;
        hmask = {48'd0, dpie_pkg::HALF_MASK} << sh;
        case (opc)
            dpie_pkg::WIDE_MOVN: wide_val = ~part;
            dpie_pkg::WIDE_MOVZ: wide_val = part;
            dpie_pkg::WIDE_MOVK: wide_val = (src_cut & ~hmask) | part;
            default:             wide_val = '0;
        endcase
        if (!sf) begin
            wide_val = {32'd0, wide_val[31:0]};
        end
    end

    always_comb begin
        o_res = '0;
        o_res.nzcv = i_nzcv;
        unique case (cls)
            dpie_pkg::CLS_ARITH: begin
                o_res.recognized = 1'b1;
                o_res.dest_index = rd;
                o_res.dest_value = ar_res;
                o_res.write_done = (rd != dpie_pkg::ZERO_REG);
                if (opc[0]) begin
                    o_res.nzcv = {n_flag, (ar_res == 64'd0), carry, v_flag};
                end
            end
            dpie_pkg::CLS_WIDE: begin
                o_res.recognized = 1'b1;
                o_res.dest_index = rd;
                o_res.dest_value = wide_val;
                o_res.write_done = (opc != dpie_pkg::WIDE_BAD) && (rd != dpie_pkg::ZERO_REG);
            end
            default: begin
                o_res.recognized = 1'b0;
            end
        endcase
    end

endmodule

### sv/dp_immediate_execute_unit.sv
// Top level of the data-processing immediate execute unit.
// Instantiates dpie_regfile and dpie_exec; depends on dpie_pkg.
//
// Usage:
// An instruction request enters on i_in_valid / o_in_ready with the 32-bit word on
// i_instruction_word. Each request gives exactly one result on o_out_valid /
// i_out_ready: recognized, write_done, destination index and value, and the flags.
// On acceptance the register file memory is read into its read data register
// while the instruction is registered; then the instruction executes, the
// destination and flags are written back, and the result is loaded into the
// output register. A new request is taken every cycle while the output is not
// stalled; the register file bypass forwards a write to the read of the very next
// request. Throughput is one instruction per cycle while the receiver does not
// stall, set by the single read and write port of the register file memory.
// When the receiver stalls, the output register holds its result, the execute stage
// holds one more request, and o_in_ready then drops until the output drains.
// Reset (synchronous, active low) empties the pipeline, clears the flags and marks
// every register invalid so that it reads as zero; no clearing pass is needed.
module dp_immediate_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instruction_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_recognized,
    output logic        o_write_done,
    output logic [4:0]  o_dest_index,
    output logic [63:0] o_dest_value,
    output logic [3:0]  o_nzcv_after
);

    logic                      in_fire;
    logic                      s1_fire;
    logic                      r_s1_valid;
    logic [31:0]               r_s1_instr;
    logic [3:0]                r_flags;
    logic                      r_out_valid;
    dpie_pkg::t_exec_res       r_out;
    dpie_pkg::t_exec_res       exec_res;
    dpie_pkg::t_wr_req         wr_req;
    logic [dpie_pkg::XLEN-1:0] src_data;
    logic [4:0]                rd_addr;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // A wide move reads its own destination (for MOVK); arithmetic reads Rn.
    assign rd_addr = (i_instruction_word[25:23] == dpie_pkg::CLS_WIDE) ?
                     i_instruction_word[4:0] : i_instruction_word[9:5];

    assign wr_req.en   = s1_fire && exec_res.write_done;
    assign wr_req.addr = exec_res.dest_index;
    assign wr_req.data = exec_res.dest_value;

    dpie_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .i_wr      (wr_req),
        .o_rd_data (src_data)
    );

    dpie_exec u_exec (
        .i_instr (r_s1_instr),
        .i_src   (src_data),
        .i_nzcv  (r_flags),
        .o_res   (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_instr <= i_instruction_word;
        end
        if (s1_fire) begin
            r_out <= exec_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= 4'd0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_flags     <= exec_res.nzcv;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_recognized = r_out.recognized;
    assign o_write_done = r_out.write_done;
    assign o_dest_index = r_out.dest_index;
    assign o_dest_value = r_out.dest_value;
    assign o_nzcv_after = r_out.nzcv;

`ifndef SYNTH
    a_flags_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_flags))
        else $error("flags changed without an executed request");
    a_flags_match_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_nzcv_after == r_flags || r_s1_valid)
        else $error("reported flags differ from architectural flags");
    a_unrecognized_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_recognized) |->
            (!o_write_done && o_dest_index == 5'd0 && o_dest_value == 64'd0))
        else $error("unrecognized request reported a write");
    a_no_zero_reg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_done) |-> o_dest_index != dpie_pkg::ZERO_REG)
        else $error("write reported for the zero register");
`endif

endmodule
